// ----- hdl/flash_field_address_planner_core_assert.svh -----
// Assertion macros shared by the flash field address planner RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef FLASH_FIELD_ADDRESS_PLANNER_CORE_ASSERT_SVH
`define FLASH_FIELD_ADDRESS_PLANNER_CORE_ASSERT_SVH

// same-cycle implication
`define FFAP_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFAP_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ffap_pkg.sv -----
// Package for the flash field address planner: widths, codes and shared types.
// No dependencies.
package ffap_pkg;

	localparam int unsigned HEADER_SIZE = 8;
	localparam int unsigned MAX_SECTORS = 64;

	localparam int ADDR_W     = 22;
	localparam int IDX_W      = 22;
	localparam int CAP_W      = 23;
	localparam int RPS_W      = 16;
	localparam int REC_W      = 9;
	localparam int SB_W       = 17;
	localparam int SC_W       = 7;
	localparam int KB_W       = 3;
	localparam int VB_W       = 8;
	localparam int KEY_W      = 32;
	localparam int LEN_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int DIVIDEND_W = 22;
	localparam int DIVISOR_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_BYTES  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_BYTES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STORE_READY  = 3'd4;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_BAD   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_READY = 2'd1;
	localparam logic [1:0] ST_BOUNDS    = 2'd2;
	localparam logic [1:0] ST_ALIGN     = 2'd3;

	localparam logic [1:0] OP_READ    = 2'd0;
	localparam logic [1:0] OP_PROGRAM = 2'd1;
	localparam logic [1:0] OP_ERASE   = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	typedef struct packed {
		logic [KB_W-1:0] key_bytes;
		logic [VB_W-1:0] value_bytes;
		logic [SB_W-1:0] sector_bytes;
		logic [SC_W-1:0] sector_count;
		logic            store_ready;
	} cfg_t;

	typedef struct packed {
		logic             ok;
		logic [REC_W-1:0] rec;
		logic [SC_W-1:0]  secs;
		logic [SB_W-1:0]  span;
	} geom_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
		logic [DIVISOR_W-1:0]  remainder;
	} div_rsp_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [1:0]        flash_op;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  length;
		logic [KEY_W-1:0]  key_data;
		logic              last;
	} res_t;

endpackage

// ----- hdl/ffap_regs.sv -----
// Configuration registers and sector geometry check for the address planner.
// Depends on ffap_pkg.
module ffap_regs import ffap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg,
	output geom_t                 geom
);

	cfg_t cfg_q;
	logic [REC_W-1:0] rec;
	logic [SC_W-1:0] secs;
	logic [SB_W-1:0] need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_bytes    <= KB_W'(4);
			cfg_q.value_bytes  <= VB_W'(4);
			cfg_q.sector_bytes <= SB_W'(4096);
			cfg_q.sector_count <= SC_W'(64);
			cfg_q.store_ready  <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_KEY_BYTES:    cfg_q.key_bytes    <= wr_data[KB_W-1:0];
				REG_VALUE_BYTES:  cfg_q.value_bytes  <= wr_data[VB_W-1:0];
				REG_SECTOR_BYTES: cfg_q.sector_bytes <= wr_data[SB_W-1:0];
				REG_SECTOR_COUNT: cfg_q.sector_count <= wr_data[SC_W-1:0];
				REG_STORE_READY:  cfg_q.store_ready  <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign rec  = REC_W'(cfg_q.key_bytes) + REC_W'(cfg_q.value_bytes);
	assign secs = (cfg_q.sector_count > SC_W'(MAX_SECTORS)) ? SC_W'(MAX_SECTORS)
		: cfg_q.sector_count;
	assign need = SB_W'(HEADER_SIZE) + SB_W'(rec);

	assign cfg       = cfg_q;
	assign geom.rec  = rec;
	assign geom.secs = secs;
	assign geom.span = cfg_q.sector_bytes - SB_W'(HEADER_SIZE);
	assign geom.ok   = (cfg_q.key_bytes != '0) && (cfg_q.key_bytes <= KB_W'(4))
		&& (cfg_q.value_bytes != '0) && (secs != '0)
		&& (cfg_q.sector_bytes >= need);

endmodule

// ----- hdl/ffap_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the planner sequencer.
// Depends on ffap_pkg.
module ffap_div import ffap_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIVIDEND_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- hdl/flash_field_address_planner_core.sv -----
// Flash field address planner: sequencer, shared multiplier and result register.
// Depends on ffap_pkg, ffap_regs, ffap_div and flash_field_address_planner_core_assert.svh.
//
//   channel  handshake              payload
//   command  start / busy           cmd, index, count, key
//   result   result_strobe          status, flash_op, address, length, key_data, last
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Read and write are bound by the divider; clear uses two divider passes and then
// emits one erase result per erased sector. After reset and after every config
// write, busy stays high while records per sector are recomputed through the same
// divider and capacity through the shared multiplier.
// Results come one per cycle and cannot be stalled.
module flash_field_address_planner_core import ffap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            cmd,
	input  logic [IDX_W-1:0]      index,
	input  logic [IDX_W-1:0]      count,
	input  logic [KEY_W-1:0]      key,
	output logic                  result_strobe,
	output logic [1:0]            status,
	output logic [1:0]            flash_op,
	output logic [ADDR_W-1:0]     address,
	output logic [LEN_W-1:0]      length,
	output logic [KEY_W-1:0]      key_data,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	`include "flash_field_address_planner_core_assert.svh"

	typedef enum logic [15:0] {
		S_RCST  = 16'h0001,
		S_RCDIV = 16'h0002,
		S_RCMUL = 16'h0004,
		S_RCCAP = 16'h0008,
		S_IDLE  = 16'h0010,
		S_CHK   = 16'h0020,
		S_DIVI  = 16'h0040,
		S_DIVC  = 16'h0080,
		S_MULQ  = 16'h0100,
		S_MULR  = 16'h0200,
		S_ADDR  = 16'h0400,
		S_KEY   = 16'h0800,
		S_VAL   = 16'h1000,
		S_MULE  = 16'h2000,
		S_ELOAD = 16'h4000,
		S_ERASE = 16'h8000
	} state_t;

	function automatic res_t fail_res(input logic [1:0] code);
		res_t r;
		r = '0;
		r.status   = code;
		r.flash_op = OP_NONE;
		r.last     = 1'b1;
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] key_mask(input logic [KB_W-1:0] kb,
		input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] m;
		unique case (kb)
			KB_W'(1): m = KEY_W'(32'h0000_00FF);
			KB_W'(2): m = KEY_W'(32'h0000_FFFF);
			KB_W'(3): m = KEY_W'(32'h00FF_FFFF);
			default:  m = '1;
		endcase
		return k & m;
	endfunction

	cfg_t     cfg;
	geom_t    geom;
	div_req_t dreq;
	div_rsp_t drsp;
	state_t   state_q, state_d;
	res_t     res_q, res_d;
	logic     strobe_q, emit, cfg_wr;

	logic [RPS_W-1:0]      rps_q;
	logic [CAP_W-1:0]      cap_q;
	logic [1:0]            cmd_q;
	logic [IDX_W-1:0]      idx_q, cnt_q, first_q;
	logic [KEY_W-1:0]      key_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [SC_W-1:0]       units_q;
	logic [CAP_W-1:0]      mul_q;
	logic [IDX_W-1:0]      mul_a;
	logic [SB_W-1:0]       mul_b;
	logic [IDX_W+SB_W-1:0] mul_full;
	logic [CAP_W-1:0]      span_sum;

	ffap_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.geom     (geom)
	);

	ffap_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign mul_full  = mul_a * mul_b;
	assign span_sum  = {1'b0, idx_q} + {1'b0, cnt_q};

	always_comb begin
		state_d       = state_q;
		emit          = 1'b0;
		res_d         = '0;
		dreq.start    = 1'b0;
		dreq.dividend = idx_q;
		dreq.divisor  = rps_q;
		mul_a         = drsp.quotient;
		mul_b         = cfg.sector_bytes;
		unique case (state_q)
			S_RCST: begin
				if (geom.ok) begin
					dreq.start    = 1'b1;
					dreq.dividend = DIVIDEND_W'(geom.span);
					dreq.divisor  = DIVISOR_W'(geom.rec);
					state_d       = S_RCDIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RCDIV: if (drsp.done) state_d = S_RCMUL;
			S_RCMUL: begin
				mul_a   = IDX_W'(rps_q);
				mul_b   = SB_W'(geom.secs);
				state_d = S_RCCAP;
			end
			S_RCCAP: state_d = S_IDLE;
			S_IDLE: begin
				if (start) state_d = S_CHK;
				else if (cfg_wr) state_d = S_RCST;
			end
			S_CHK: begin
				priority if (!cfg.store_ready) begin
					emit    = 1'b1;
					res_d   = fail_res(ST_NOT_READY);
					state_d = S_IDLE;
				end else if (cmd_q == CMD_BAD) begin
					emit    = 1'b1;
					res_d   = fail_res(ST_ALIGN);
					state_d = S_IDLE;
				end else if (({1'b0, idx_q} >= cap_q) || (rps_q == '0)) begin
					emit    = 1'b1;
					res_d   = fail_res(ST_BOUNDS);
					state_d = S_IDLE;
				end else begin
					dreq.start = 1'b1;
					state_d    = S_DIVI;
				end
			end
			S_DIVI: begin
				if (drsp.done) begin
					if (cmd_q == CMD_CLEAR) begin
						if (drsp.remainder != '0) begin
							emit    = 1'b1;
							res_d   = fail_res(ST_ALIGN);
							state_d = S_IDLE;
						end else begin
							dreq.start    = 1'b1;
							dreq.dividend = cnt_q;
							state_d       = S_DIVC;
						end
					end else begin
						state_d = S_MULQ;
					end
				end
			end
			S_DIVC: begin
				if (drsp.done) begin
					priority if (drsp.remainder != '0) begin
						emit    = 1'b1;
						res_d   = fail_res(ST_ALIGN);
						state_d = S_IDLE;
					end else if (span_sum > cap_q) begin
						emit    = 1'b1;
						res_d   = fail_res(ST_BOUNDS);
						state_d = S_IDLE;
					end else if (drsp.quotient == '0) begin
						emit    = 1'b1;
						res_d   = fail_res(ST_OK);
						state_d = S_IDLE;
					end else begin
						state_d = S_MULE;
					end
				end
			end
			S_MULQ: state_d = S_MULR;
			S_MULR: begin
				mul_a   = IDX_W'(drsp.remainder);
				mul_b   = SB_W'(geom.rec);
				state_d = S_ADDR;
			end
			S_ADDR: state_d = S_KEY;
			S_KEY: begin
				emit           = 1'b1;
				res_d.status   = ST_OK;
				res_d.flash_op = (cmd_q == CMD_WRITE) ? OP_PROGRAM : OP_READ;
				res_d.address  = addr_q;
				res_d.length   = LEN_W'(cfg.key_bytes);
				res_d.key_data = (cmd_q == CMD_WRITE) ? key_mask(cfg.key_bytes, key_q) : '0;
				res_d.last     = 1'b0;
				state_d        = S_VAL;
			end
			S_VAL: begin
				emit           = 1'b1;
				res_d.status   = ST_OK;
				res_d.flash_op = (cmd_q == CMD_WRITE) ? OP_PROGRAM : OP_READ;
				res_d.address  = addr_q + ADDR_W'(cfg.key_bytes);
				res_d.length   = cfg.value_bytes;
				res_d.last     = 1'b1;
				state_d        = S_IDLE;
			end
			S_MULE: begin
				mul_a   = first_q;
				state_d = S_ELOAD;
			end
			S_ELOAD: state_d = S_ERASE;
			S_ERASE: begin
				emit           = 1'b1;
				res_d.status   = ST_OK;
				res_d.flash_op = OP_ERASE;
				res_d.address  = addr_q;
				res_d.last     = (units_q == SC_W'(1));
				if (units_q == SC_W'(1)) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_RCST;
			strobe_q <= 1'b0;
			rps_q    <= '0;
			cap_q    <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (state_q == S_RCST && !geom.ok) begin
				rps_q <= '0;
				cap_q <= '0;
			end
			if (state_q == S_RCDIV && drsp.done) rps_q <= drsp.quotient[RPS_W-1:0];
			if (state_q == S_RCCAP) cap_q <= mul_q;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_full[CAP_W-1:0];
		if (emit) res_q <= res_d;
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
			idx_q <= index;
			cnt_q <= count;
			key_q <= key;
		end
		if (state_q == S_DIVI && drsp.done) first_q <= drsp.quotient;
		if (state_q == S_DIVC && drsp.done) units_q <= drsp.quotient[SC_W-1:0];
		if (state_q == S_MULR) addr_q <= mul_q[ADDR_W-1:0] + ADDR_W'(HEADER_SIZE);
		if (state_q == S_ADDR) addr_q <= addr_q + mul_q[ADDR_W-1:0];
		if (state_q == S_ELOAD) addr_q <= mul_q[ADDR_W-1:0];
		if (state_q == S_ERASE) begin
			addr_q  <= addr_q + ADDR_W'(cfg.sector_bytes);
			units_q <= units_q - 1'b1;
		end
	end

	assign result_strobe = strobe_q;
	assign status        = res_q.status;
	assign flash_op      = res_q.flash_op;
	assign address       = res_q.address;
	assign length        = res_q.length;
	assign key_data      = res_q.key_data;
	assign last          = res_q.last;

	`FFAP_ASSERT_NXT(a_req_sets_busy, start && !busy, busy, "request accepted but busy low")
	`FFAP_ASSERT_NXT(a_cfg_recompute, cfg_valid && cfg_ready, busy, "no recompute after config write")
	`FFAP_ASSERT_IMP(a_err_single, result_strobe && (status != ST_OK), last && (flash_op == OP_NONE), "error result not final")
	`FFAP_ASSERT_NXT(a_last_gap, result_strobe && last, !result_strobe, "result right after final result")

endmodule
